// ----- design/ssa_pkg.sv -----
`default_nettype none

package ssa_pkg;

    localparam int NUM_HANDLES_DEF      = 1024;
    localparam int PAGE_SHIFT_SMALL_DEF = 12;
    localparam int PAGE_SHIFT_LARGE_DEF = 21;

    localparam int SLOT_W  = 48;
    localparam int BYTES_W = 41;

    localparam logic [BYTES_W-1:0] TOTAL_RESET = 41'd1048576;

    localparam logic ACT_RESERVE = 1'b0;
    localparam logic ACT_FREE    = 1'b1;

    // Live mark bits: one per page kind.
    localparam logic [1:0] MARK_SMALL = 2'b01;
    localparam logic [1:0] MARK_LARGE = 2'b10;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NOSPACE  = 2'd1,
        ST_ACCT_ERR = 2'd2
    } t_status;

endpackage

`default_nettype wire

// ----- design/ssa_if.sv -----
`default_nettype none

interface ssa_req_if;
    import ssa_pkg::*;

    logic              valid;
    logic              ready;
    logic              action;
    logic              huge;
    logic [SLOT_W-1:0] slot_id;

    modport source (output valid, output action, output huge, output slot_id, input ready);
    modport sink   (input valid, input action, input huge, input slot_id, output ready);
endinterface

interface ssa_rsp_if;
    import ssa_pkg::*;

    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic [SLOT_W-1:0]  granted_id;
    logic               released;
    logic [BYTES_W-1:0] bytes_remaining;

    modport source (output valid, output status, output granted_id, output released,
                    output bytes_remaining, input ready);
    modport sink   (input valid, input status, input granted_id, input released,
                    input bytes_remaining, output ready);
endinterface

interface ssa_cfg_if;
    import ssa_pkg::*;

    logic               valid;
    logic               ready;
    logic [BYTES_W-1:0] total_bytes;

    modport source (output valid, output total_bytes, input ready);
    modport sink   (input valid, input total_bytes, output ready);
endinterface

`default_nettype wire

// ----- design/ssa_decode.sv -----
`default_nettype none

module ssa_decode #(
    parameter int NUM_HANDLES      = ssa_pkg::NUM_HANDLES_DEF,
    parameter int PAGE_SHIFT_SMALL = ssa_pkg::PAGE_SHIFT_SMALL_DEF,
    parameter int PAGE_SHIFT_LARGE = ssa_pkg::PAGE_SHIFT_LARGE_DEF,
    parameter int HW               = $clog2(NUM_HANDLES)
) (
    input  wire logic                      i_huge,
    input  wire logic [ssa_pkg::SLOT_W-1:0] i_slot_id,
    output logic      [HW-1:0]             o_hnd,
    output logic                           o_known
);
    import ssa_pkg::*;

    localparam logic [SLOT_W-1:0] MASK_S = (SLOT_W'(1) << PAGE_SHIFT_SMALL) - SLOT_W'(1);
    localparam logic [SLOT_W-1:0] MASK_L = (SLOT_W'(1) << PAGE_SHIFT_LARGE) - SLOT_W'(1);

    logic [SLOT_W-1:0] w_full;
    logic              w_exact;

    // A slot id is known only if it sits exactly on a page boundary of its
    // kind and its handle falls inside the table.
    always_comb begin
        if (i_huge) begin
            w_full  = i_slot_id >> PAGE_SHIFT_LARGE;
            w_exact = (i_slot_id & MASK_L) == '0;
        end else begin
            w_full  = i_slot_id >> PAGE_SHIFT_SMALL;
            w_exact = (i_slot_id & MASK_S) == '0;
        end
    end

    assign o_known = w_exact && (w_full < SLOT_W'(NUM_HANDLES));
    assign o_hnd   = w_full[HW-1:0];

endmodule

`default_nettype wire

// ----- design/swap_slot_allocator.sv -----
`default_nettype none

// Swap slot allocator.
// i_req carries one word per operation: action (reserve or free), huge (page
// kind) and slot_id (used by a free only). o_rsp returns one word per request
// with status, granted_id, released and bytes_remaining. i_cfg writes the
// capacity in bytes and reloads the remaining byte budget from it.
// Live marks and the free queue live in synchronous memories with registered read data.
// A free, or a reserve while the free queue is empty, goes through one mark
// memory read (S_IDLE) and one write back (S_EXEC) from acceptance until the
// next request can be taken. A reserve while the free queue holds handles also
// passes through S_QRD, since the handle must first come out of the queue memory before its mark is read.
// The response is registered and shows up at the cycle after the write back.
// After reset the block sweeps the live mark memory, one entry per cycle,
// through all NUM_HANDLES entries; i_req.ready stays low meanwhile, configuration
// writes are accepted at any time. When the receiver stalls, the finished
// response waits in the output register and the next request is accepted;
// it is held in its write-back step until the output register is free.
module swap_slot_allocator #(
    parameter int NUM_HANDLES      = ssa_pkg::NUM_HANDLES_DEF,
    parameter int PAGE_SHIFT_SMALL = ssa_pkg::PAGE_SHIFT_SMALL_DEF,
    parameter int PAGE_SHIFT_LARGE = ssa_pkg::PAGE_SHIFT_LARGE_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    ssa_req_if.sink    i_req,
    ssa_rsp_if.source  o_rsp,
    ssa_cfg_if.sink    i_cfg
);
    import ssa_pkg::*;

    localparam int HW = $clog2(NUM_HANDLES);
    localparam int CW = $clog2(NUM_HANDLES + 1);

    localparam logic [HW-1:0]      LAST_HND = HW'(NUM_HANDLES - 1);
    localparam logic [CW-1:0]      FULL_CNT = CW'(NUM_HANDLES);
    localparam logic [BYTES_W-1:0] SIZE_S   = BYTES_W'(1) << PAGE_SHIFT_SMALL;
    localparam logic [BYTES_W-1:0] SIZE_L   = BYTES_W'(1) << PAGE_SHIFT_LARGE;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_QRD,
        S_EXEC
    } t_state;

    t_state r_state, n_state;

    logic [HW-1:0]      r_clr, n_clr;
    logic [HW-1:0]      r_head, n_head;
    logic [HW-1:0]      r_tail, n_tail;
    logic [CW-1:0]      r_count, n_count;
    logic [CW-1:0]      r_bump, n_bump;
    logic [BYTES_W-1:0] r_bytes, n_bytes;
    logic [BYTES_W-1:0] r_total, n_total;

    logic               r_action, n_action;
    logic               r_huge, n_huge;
    logic               r_known, n_known;
    logic [HW-1:0]      r_hnd, n_hnd;

    logic               r_out_valid, n_out_valid;
    t_status            r_status, n_status;
    logic [SLOT_W-1:0]  r_granted, n_granted;
    logic               r_released, n_released;
    logic [BYTES_W-1:0] r_remaining, n_remaining;

    // Memories and their registered read data.
    logic [HW-1:0] r_queue_mem [NUM_HANDLES];
    logic [1:0]    r_mark_mem  [NUM_HANDLES];
    logic [HW-1:0] r_q_rdata;
    logic [1:0]    r_mark_rd;

    logic          w_q_rd_en;
    logic          w_q_wr_en;
    logic          w_mark_rd_en;
    logic [HW-1:0] w_mark_rd_addr;
    logic          w_mark_wr_en;
    logic [HW-1:0] w_mark_wr_addr;
    logic [1:0]    w_mark_wr_data;

    logic               w_accept;
    logic               w_out_free;
    logic [HW-1:0]      w_dec_hnd;
    logic               w_dec_known;
    logic [BYTES_W-1:0] w_size;
    logic [1:0]         w_bit;
    logic               w_short;
    logic               w_exhausted;
    logic               w_live;
    logic [BYTES_W:0]   w_credit;
    logic [SLOT_W-1:0]  w_grant_id;

    ssa_decode #(
        .NUM_HANDLES      (NUM_HANDLES),
        .PAGE_SHIFT_SMALL (PAGE_SHIFT_SMALL),
        .PAGE_SHIFT_LARGE (PAGE_SHIFT_LARGE),
        .HW               (HW)
    ) u_decode (
        .i_huge    (i_req.huge),
        .i_slot_id (i_req.slot_id),
        .o_hnd     (w_dec_hnd),
        .o_known   (w_dec_known)
    );

    assign i_req.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign w_accept    = i_req.valid && (r_state == S_IDLE);
    assign w_out_free  = !r_out_valid || o_rsp.ready;

    assign o_rsp.valid           = r_out_valid;
    assign o_rsp.status          = r_status;
    assign o_rsp.granted_id      = r_granted;
    assign o_rsp.released        = r_released;
    assign o_rsp.bytes_remaining = r_remaining;

    assign w_size      = r_huge ? SIZE_L : SIZE_S;
    assign w_bit       = r_huge ? MARK_LARGE : MARK_SMALL;
    assign w_short     = r_bytes < w_size;
    assign w_exhausted = (r_count == '0) && (r_bump == FULL_CNT);
    assign w_live      = r_known && ((r_mark_rd & w_bit) != 2'b00);
    assign w_credit    = w_live ? ({1'b0, r_bytes} + {1'b0, w_size}) : {1'b0, r_bytes};
    assign w_grant_id  = r_huge ? (SLOT_W'(r_hnd) << PAGE_SHIFT_LARGE)
                                : (SLOT_W'(r_hnd) << PAGE_SHIFT_SMALL);

    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_head      = r_head;
        n_tail      = r_tail;
        n_count     = r_count;
        n_bump      = r_bump;
        n_bytes     = r_bytes;
        n_total     = r_total;
        n_action    = r_action;
        n_huge      = r_huge;
        n_known     = r_known;
        n_hnd       = r_hnd;
        n_out_valid = r_out_valid && !o_rsp.ready;
        n_status    = r_status;
        n_granted   = r_granted;
        n_released  = r_released;
        n_remaining = r_remaining;

        w_q_rd_en      = 1'b0;
        w_q_wr_en      = 1'b0;
        w_mark_rd_en   = 1'b0;
        w_mark_rd_addr = r_hnd;
        w_mark_wr_en   = 1'b0;
        w_mark_wr_addr = r_hnd;
        w_mark_wr_data = r_mark_rd;

        case (r_state)
            S_CLEAR: begin
                w_mark_wr_en   = 1'b1;
                w_mark_wr_addr = r_clr;
                w_mark_wr_data = 2'b00;
                n_clr          = r_clr + HW'(1);
                if (r_clr == LAST_HND) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_action  = i_req.action;
                    n_huge    = i_req.huge;
                    n_known   = w_dec_known;
                    w_q_rd_en = 1'b1;
                    // Look up the mark now; if the handle still has to come out of the free
                    // queue, the lookup is made again in S_QRD.
                    w_mark_rd_en   = 1'b1;
                    w_mark_rd_addr = (i_req.action == ACT_FREE) ? w_dec_hnd : r_bump[HW-1:0];
                    n_hnd          = w_mark_rd_addr;
                    if (i_req.action == ACT_RESERVE && r_count != '0) begin
                        n_state = S_QRD;
                    end else begin
                        n_state = S_EXEC;
                    end
                end
            end
            S_QRD: begin
                w_mark_rd_en   = 1'b1;
                w_mark_rd_addr = r_q_rdata;
                n_hnd          = r_q_rdata;
                n_state        = S_EXEC;
            end
            S_EXEC: begin
                if (w_out_free) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                    n_granted   = '0;
                    n_released  = 1'b0;
                    if (r_action == ACT_RESERVE) begin
                        if (w_short || w_exhausted) begin
                            n_status = ST_NOSPACE;
                        end else begin
                            n_status       = ST_OK;
                            n_granted      = w_grant_id;
                            w_mark_wr_en   = 1'b1;
                            w_mark_wr_data = r_mark_rd | w_bit;
                            n_bytes        = r_bytes - w_size;
                            if (r_count != '0) begin
                                n_head  = (r_head == LAST_HND) ? '0 : r_head + HW'(1);
                                n_count = r_count - CW'(1);
                            end else begin
                                n_bump = r_bump + CW'(1);
                            end
                        end
                    end else begin
                        n_status = ST_OK;
                        if (w_live) begin
                            n_released     = 1'b1;
                            w_mark_wr_en   = 1'b1;
                            w_mark_wr_data = r_mark_rd & ~w_bit;
                            if (r_count != FULL_CNT) begin
                                w_q_wr_en = 1'b1;
                                n_tail    = (r_tail == LAST_HND) ? '0 : r_tail + HW'(1);
                                n_count   = r_count + CW'(1);
                            end
                        end
                        // A credit beyond the capacity is clamped and flagged.
                        if (w_credit > {1'b0, r_total}) begin
                            n_bytes  = r_total;
                            n_status = ST_ACCT_ERR;
                        end else begin
                            n_bytes = w_credit[BYTES_W-1:0];
                        end
                    end
                    n_remaining = n_bytes;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (i_cfg.valid) begin
            n_total = i_cfg.total_bytes;
            n_bytes = i_cfg.total_bytes;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_bump      <= '0;
            r_bytes     <= TOTAL_RESET;
            r_total     <= TOTAL_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
            r_bump      <= n_bump;
            r_bytes     <= n_bytes;
            r_total     <= n_total;
            r_out_valid <= n_out_valid;
            r_action    <= n_action;
            r_huge      <= n_huge;
            r_known     <= n_known;
            r_hnd       <= n_hnd;
            r_status    <= n_status;
            r_granted   <= n_granted;
            r_released  <= n_released;
            r_remaining <= n_remaining;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_q_wr_en) begin
            r_queue_mem[r_tail] <= r_hnd;
        end
        if (w_q_rd_en) begin
            r_q_rdata <= r_queue_mem[r_head];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_mark_wr_en) begin
            r_mark_mem[w_mark_wr_addr] <= w_mark_wr_data;
        end
        if (w_mark_rd_en) begin
            r_mark_rd <= r_mark_mem[w_mark_rd_addr];
        end
    end

    // Every queued handle was handed out by the bump counter first.
    a_count_le_bump: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= r_bump)
        else $error("free queue holds more handles than were ever issued");

    a_bytes_le_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bytes <= r_total)
        else $error("byte budget exceeds capacity");

    a_nospace_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && o_rsp.status == ST_NOSPACE |-> o_rsp.granted_id == '0 && !o_rsp.released)
        else $error("no-space response carries a grant or release");

    a_no_write_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_mark_wr_en && w_mark_rd_en))
        else $error("mark memory read and written in the same cycle");

endmodule

`default_nettype wire
